/* rtl/hashed_value_noise_3d_defines.svh */
// hashed_value_noise_3d_defines.svh: assertion macros for the noise pipeline
// used by the files that carry concurrent assertions; expects clk and rst in scope
`ifndef HASHED_VALUE_NOISE_3D_DEFINES_SVH
`define HASHED_VALUE_NOISE_3D_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define HVN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HVN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/hvn_pkg.sv */
// hvn_pkg: types and constants of the hashed value noise pipeline
// no dependencies; imported by every module of the block
`default_nettype none

package hvn_pkg;

  // fixed-point formats
  localparam int COORD_FRAC_BITS = 12;
  localparam int SCALE_FRAC_BITS = 24;
  localparam int LAT_SHIFT       = COORD_FRAC_BITS + SCALE_FRAC_BITS - 16;
  localparam int SCALE_W         = 24;
  localparam int FREQ_W          = 26;
  localparam int PROD_W          = 32 + FREQ_W + 1;

  localparam logic [SCALE_W-1:0] CFG_SCALE_RESET = 24'd671089;

  // fixed frequencies, rounded to the scale format
  localparam logic [FREQ_W-1:0] FREQ_BIOME =
    FREQ_W'(((64'd81 << SCALE_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic [FREQ_W-1:0] FREQ_BASE =
    FREQ_W'(((64'd33 << SCALE_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic [FREQ_W-1:0] FREQ_DETAIL =
    FREQ_W'(((64'd17 << SCALE_FRAC_BITS) + 64'd500) / 64'd1000);

  // cave frequency factors, Q2.16
  localparam logic [17:0] FACT_1P7 = 18'd111411;
  localparam logic [17:0] FACT_2P2 = 18'd144179;
  localparam logic [17:0] FACT_1P1 = 18'd72090;

  // hash constants
  localparam logic [31:0] HASH_X  = 32'h9E3779B1;
  localparam logic [31:0] HASH_Y  = 32'h85EBCA77;
  localparam logic [31:0] HASH_Z  = 32'hC2B2AE3D;
  localparam logic [31:0] SCR_K1  = 32'h7feb352d;
  localparam logic [31:0] SCR_K2  = 32'h846ca68b;

  // per-octave salts
  localparam logic [31:0] SALT_CAVE_A  = 32'hA7F3C911;
  localparam logic [31:0] SALT_CAVE_B  = 32'h1F123BB5;
  localparam logic [31:0] SALT_BIOME   = 32'hBC119D17;
  localparam logic [31:0] SALT_BASE    = 32'hD2A41E6B;
  localparam logic [31:0] SALT_DETAIL  = 32'h4E67C6A1;

  // cell offset of the second cave octave
  localparam logic [31:0] CAVE_B_OFFSET = 32'd100;

  // octave blend weights, Q0.16
  localparam logic [15:0] W_CAVE_A    = 16'd45875;
  localparam logic [15:0] W_CAVE_B    = 16'd19661;
  localparam logic [15:0] W_TERRAIN_A = 16'd49152;
  localparam logic [15:0] W_TERRAIN_B = 16'd16384;

  typedef enum logic [1:0] {
    MODE_CAVE    = 2'd0,
    MODE_BIOME   = 2'd1,
    MODE_TERRAIN = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  // cave frequencies derived from the register
  typedef struct packed {
    logic [FREQ_W-1:0] base;
    logic [FREQ_W-1:0] y17;
    logic [FREQ_W-1:0] x22;
    logic [FREQ_W-1:0] y11;
  } cave_freq_t;

  // lattice cell, fraction and salt of one octave
  typedef struct packed {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic [15:0] tx;
    logic [15:0] ty;
    logic [15:0] tz;
    logic [31:0] salt;
  } lattice_t;

endpackage

`default_nettype wire

/* rtl/hvn_cfg.sv */
// hvn_cfg: cave scale register and the cave frequencies derived from it
// depends on hvn_pkg
`default_nettype none

module hvn_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         wr,
  input  wire logic [hvn_pkg::SCALE_W-1:0]  wr_data,
  output hvn_pkg::cave_freq_t               freq
);
  import hvn_pkg::*;

  logic [SCALE_W-1:0] scale;
  logic [41:0]        p17, p22, p11;

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= CFG_SCALE_RESET;
    end else if (wr) begin
      scale <= wr_data;
    end
  end

  // scaled frequencies, rounded back to the scale format
  always_comb begin
    p17 = 42'(scale) * 42'(FACT_1P7) + 42'd32768;
    p22 = 42'(scale) * 42'(FACT_2P2) + 42'd32768;
    p11 = 42'(scale) * 42'(FACT_1P1) + 42'd32768;
  end

  always_ff @(posedge clk) begin
    freq.base <= FREQ_W'(scale);
    freq.y17  <= p17[16 +: FREQ_W];
    freq.x22  <= p22[16 +: FREQ_W];
    freq.y11  <= p11[16 +: FREQ_W];
  end

endmodule

`default_nettype wire

/* rtl/hvn_lattice.sv */
// hvn_lattice: per-mode frequency and salt selection, world to lattice scaling
// depends on hvn_pkg; one register stage
`default_nettype none

module hvn_lattice (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire hvn_pkg::mode_t      mode,
  input  wire logic signed [31:0]  wx,
  input  wire logic signed [31:0]  wy,
  input  wire logic signed [31:0]  wz,
  input  wire hvn_pkg::cave_freq_t freq,
  output hvn_pkg::lattice_t        lat_a,
  output hvn_pkg::lattice_t        lat_b
);
  import hvn_pkg::*;

  logic [FREQ_W-1:0] fa_x, fa_y, fa_z, fb_x, fb_y, fb_z;
  logic [31:0]       salt_a, salt_b;
  logic              add_b;
  logic [47:0]       pa_x, pa_y, pa_z, pb_x, pb_y, pb_z;

  // lattice position with a 16-bit fraction, floored
  function automatic logic [47:0] lat_pos(input logic signed [31:0] wv,
                                          input logic [FREQ_W-1:0] f);
    logic signed [PROD_W-1:0] prod;
    prod = $signed(wv) * $signed({1'b0, f});
    return 48'(prod >>> LAT_SHIFT);
  endfunction

  // frequencies and salts per mode
  always_comb begin
    fa_x   = '0;
    fa_y   = '0;
    fa_z   = '0;
    fb_x   = '0;
    fb_y   = '0;
    fb_z   = '0;
    salt_a = '0;
    salt_b = '0;
    add_b  = 1'b0;
    unique case (mode)
      MODE_CAVE: begin
        fa_x   = freq.base;
        fa_y   = freq.y17;
        fa_z   = freq.base;
        fb_x   = freq.x22;
        fb_y   = freq.y11;
        fb_z   = freq.x22;
        salt_a = SALT_CAVE_A;
        salt_b = SALT_CAVE_B;
        add_b  = 1'b1;
      end
      MODE_BIOME: begin
        fa_x   = FREQ_BIOME;
        fa_z   = FREQ_BIOME;
        salt_a = SALT_BIOME;
      end
      MODE_TERRAIN: begin
        fa_x   = FREQ_BASE;
        fa_z   = FREQ_BASE;
        fb_x   = FREQ_DETAIL;
        fb_z   = FREQ_DETAIL;
        salt_a = SALT_BASE;
        salt_b = SALT_DETAIL;
      end
      MODE_NONE: begin
        salt_a = '0;
      end
      default: begin
        salt_a = '0;
      end
    endcase
  end

  // scaling multipliers
  always_comb begin
    pa_x = lat_pos(wx, fa_x);
    pa_y = lat_pos(wy, fa_y);
    pa_z = lat_pos(wz, fa_z);
    pb_x = lat_pos(wx, fb_x);
    pb_y = lat_pos(wy, fb_y);
    pb_z = lat_pos(wz, fb_z);
  end

  // split into cell and fraction, offset the second cave octave
  always_ff @(posedge clk) begin
    if (en) begin
      lat_a.cx   <= pa_x[47:16];
      lat_a.cy   <= pa_y[47:16];
      lat_a.cz   <= pa_z[47:16];
      lat_a.tx   <= pa_x[15:0];
      lat_a.ty   <= pa_y[15:0];
      lat_a.tz   <= pa_z[15:0];
      lat_a.salt <= salt_a;
      lat_b.cx   <= pb_x[47:16] + (add_b ? CAVE_B_OFFSET : 32'd0);
      lat_b.cy   <= pb_y[47:16];
      lat_b.cz   <= pb_z[47:16] + (add_b ? CAVE_B_OFFSET : 32'd0);
      lat_b.tx   <= pb_x[15:0];
      lat_b.ty   <= pb_y[15:0];
      lat_b.tz   <= pb_z[15:0];
      lat_b.salt <= salt_b;
    end
  end

endmodule

`default_nettype wire

/* rtl/hvn_octave.sv */
// hvn_octave: one octave of value noise, corner hashing, fade and trilinear lerp
// depends on hvn_pkg; six register stages from lattice to noise
`default_nettype none

module hvn_octave (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire hvn_pkg::lattice_t  lat,
  output logic signed [16:0]      noise
);
  import hvn_pkg::*;

  // stage 3: axis hashes and squared fractions
  logic [31:0] hx, hy, hz, salt3;
  logic [31:0] t2x, t2y, t2z;
  logic [15:0] tx3, ty3, tz3;
  // stage 4: first scramble round and fade weights
  logic [31:0] h1 [8];
  logic [16:0] fu4, fv4, fw4;
  // stage 5: second scramble round
  logic [31:0] h2 [8];
  logic [16:0] fu5, fv5, fw5;
  // stage 6 to 8: lerps along x, y, z
  logic signed [16:0] ax [4];
  logic [16:0]        fv6, fw6;
  logic signed [16:0] by [2];
  logic [16:0]        fw7;

  logic [31:0]        hpre [8];
  logic [31:0]        hmid [8];
  logic signed [16:0] cv   [8];
  logic [31:0]        hfin [8];

  function automatic logic [16:0] fade16(input logic [31:0] t2, input logic [15:0] t);
    logic [17:0] k;
    logic [50:0] fp;
    k  = 18'd196608 - {1'b0, t, 1'b0};
    fp = 51'(t2) * 51'(k) + 51'h8000_0000;
    return fp[48:32];
  endfunction

  function automatic logic signed [16:0] lerp16(input logic signed [16:0] a,
                                                input logic signed [16:0] b,
                                                input logic [16:0] w);
    logic signed [17:0] d;
    logic signed [35:0] p;
    d = 18'(b) - 18'(a);
    p = d * $signed({1'b0, w}) + 36'sd32768;
    return 17'(18'(a) + 18'(p >>> 16));
  endfunction

  // stage 3
  always_ff @(posedge clk) begin
    if (en) begin
      hx    <= lat.cx * HASH_X;
      hy    <= lat.cy * HASH_Y;
      hz    <= lat.cz * HASH_Z;
      salt3 <= lat.salt;
      t2x   <= 32'(lat.tx) * 32'(lat.tx);
      t2y   <= 32'(lat.ty) * 32'(lat.ty);
      t2z   <= 32'(lat.tz) * 32'(lat.tz);
      tx3   <= lat.tx;
      ty3   <= lat.ty;
      tz3   <= lat.tz;
    end
  end

  // corner hash inputs, neighbor hash is the axis hash plus its constant
  always_comb begin
    for (int c = 0; c < 8; c++) begin
      hpre[c] = (c[0] ? hx + HASH_X : hx) ^ (c[1] ? hy + HASH_Y : hy) ^
                (c[2] ? hz + HASH_Z : hz) ^ salt3;
      hpre[c] = hpre[c] ^ (hpre[c] >> 16);
    end
  end

  // stage 4
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 8; c++) begin
        h1[c] <= hpre[c] * SCR_K1;
      end
      fu4 <= fade16(t2x, tx3);
      fv4 <= fade16(t2y, ty3);
      fw4 <= fade16(t2z, tz3);
    end
  end

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      hmid[c] = h1[c] ^ (h1[c] >> 15);
    end
  end

  // stage 5
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 8; c++) begin
        h2[c] <= hmid[c] * SCR_K2;
      end
      fu5 <= fu4;
      fv5 <= fv4;
      fw5 <= fw4;
    end
  end

  // corner values in [-1,1): top 17 bits with the sign bit flipped
  always_comb begin
    for (int c = 0; c < 8; c++) begin
      hfin[c] = h2[c] ^ (h2[c] >> 16);
      cv[c]   = $signed({~hfin[c][31], hfin[c][30:15]});
    end
  end

  // stage 6: lerp along x
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        ax[j] <= lerp16(cv[2*j], cv[2*j+1], fu5);
      end
      fv6 <= fv5;
      fw6 <= fw5;
    end
  end

  // stage 7: lerp along y
  always_ff @(posedge clk) begin
    if (en) begin
      by[0] <= lerp16(ax[0], ax[1], fv6);
      by[1] <= lerp16(ax[2], ax[3], fv6);
      fw7   <= fw6;
    end
  end

  // stage 8: lerp along z
  always_ff @(posedge clk) begin
    if (en) begin
      noise <= lerp16(by[0], by[1], fw7);
    end
  end

endmodule

`default_nettype wire

/* rtl/hashed_value_noise_3d.sv */
// hashed_value_noise_3d: top level of the 3d value noise pipeline
// depends on hvn_pkg, hvn_cfg, hvn_lattice, hvn_octave and the defines header
//
// One item per clock while the output is not held: every cycle a new sample point
// may enter, and its noise value passes nine register stages (input register,
// lattice scaling, six octave stages, and the blend into the output register).
// Both octaves run side by side in their own lanes. A stall on the output while
// a finished item is presented freezes the whole pipeline and shows at in_stall
// in the same cycle. cfg_scale, the cave frequency, is taken while cfg_ready is
// high (always, outside reset); the derived cave frequencies are registered
// after the scale register, so write it while no item is in flight.
`default_nettype none
`include "hashed_value_noise_3d_defines.svh"

module hashed_value_noise_3d (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [hvn_pkg::SCALE_W-1:0]  cfg_scale,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   mode,
  input  wire logic signed [31:0]           world_x,
  input  wire logic signed [31:0]           world_y,
  input  wire logic signed [31:0]           world_z,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [15:0]                noise_value
);
  import hvn_pkg::*;

  logic               adv;
  logic [1:9]         vld;
  mode_t              mode1;
  logic signed [31:0] wx1, wy1, wz1;
  mode_t              mode_line [2:8];
  mode_t              out_mode;
  cave_freq_t         freq;
  lattice_t           lat_a, lat_b;
  logic signed [16:0] n_a, n_b;
  logic [15:0]        w_a, w_b;
  logic signed [34:0] mix;
  logic signed [17:0] half;
  logic signed [15:0] noise_next;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sd32767;
    end else if (v < -18'sd32768) begin
      return -16'sd32768;
    end
    return 16'(v);
  endfunction

  // handshake: the pipeline moves unless a finished item is held
  assign adv       = !(vld[9] && out_stall);
  assign in_stall  = !adv || rst;
  assign out_valid = vld[9];
  assign cfg_ready = !rst;

  hvn_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .wr      (cfg_valid && cfg_ready),
    .wr_data (cfg_scale),
    .freq    (freq)
  );

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld[1] <= in_valid;
      for (int i = 2; i <= 9; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  // input register and mode line
  always_ff @(posedge clk) begin
    if (adv) begin
      mode1        <= mode_t'(mode);
      wx1          <= world_x;
      wy1          <= world_y;
      wz1          <= world_z;
      mode_line[2] <= mode1;
      for (int i = 3; i <= 8; i++) begin
        mode_line[i] <= mode_line[i-1];
      end
    end
  end

  hvn_lattice u_lattice (
    .clk   (clk),
    .en    (adv),
    .mode  (mode1),
    .wx    (wx1),
    .wy    (wy1),
    .wz    (wz1),
    .freq  (freq),
    .lat_a (lat_a),
    .lat_b (lat_b)
  );

  hvn_octave u_oct_a (
    .clk   (clk),
    .en    (adv),
    .lat   (lat_a),
    .noise (n_a)
  );

  hvn_octave u_oct_b (
    .clk   (clk),
    .en    (adv),
    .lat   (lat_b),
    .noise (n_b)
  );

  // octave blend and saturation
  always_comb begin
    w_a = W_CAVE_A;
    w_b = W_CAVE_B;
    if (mode_line[8] == MODE_TERRAIN) begin
      w_a = W_TERRAIN_A;
      w_b = W_TERRAIN_B;
    end
    mix  = n_a * $signed({1'b0, w_a}) + n_b * $signed({1'b0, w_b}) + 35'sd65536;
    half = (18'(n_a) + 18'sd1) >>> 1;
    unique case (mode_line[8])
      MODE_CAVE, MODE_TERRAIN: noise_next = sat16(18'(mix >>> 17));
      MODE_BIOME:              noise_next = sat16(half);
      MODE_NONE:               noise_next = '0;
      default:                 noise_next = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      noise_value <= noise_next;
      out_mode    <= mode_line[8];
    end
  end

  `HVN_ASSERT_NOW(a_stall_back, out_valid && out_stall, in_stall, "held item did not stall input")
  `HVN_ASSERT_NEXT(a_accept_valid, in_valid && !in_stall, vld[1], "accepted item lost at entry")
  `HVN_ASSERT_NEXT(a_stall_hold, in_stall, $stable(vld), "pipeline moved while stalled")
  `HVN_ASSERT_NOW(a_none_zero, out_valid && out_mode == MODE_NONE, noise_value == 16'sd0,
    "unused mode gave nonzero noise")

endmodule

`default_nettype wire
